// ===== src/mhtq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhtq_pkg
// Shared constants, codes and types of the min-heap timer queue.
// ----------------------------------------------------------------------------
package mhtq_pkg;

    localparam int HEAP_DEPTH   = 64;
    localparam int IDX_W        = $clog2(HEAP_DEPTH);
    localparam int CNT_W        = $clog2(HEAP_DEPTH + 1);
    localparam int HANDLE_COUNT = 256;
    localparam int HANDLE_W     = 8;
    localparam int TIME_BITS    = 32;
    localparam int TIMEOUT_W    = 31;
    localparam int WAIT_W       = 31;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int IN_DATA_W    = 72;
    localparam int OUT_DATA_W   = 48;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_ADJUST = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_TICK   = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // Heap read port addressing.
    typedef enum logic [1:0] {
        RD_ENDS,
        RD_CHILD,
        RD_PARENT
    } t_rd_sel;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_REARM_START,
        OP_ADD_START,
        OP_DEL_START,
        OP_DEL_TAIL,
        OP_POP_START,
        OP_POP_TAIL,
        OP_DOWN_STEP,
        OP_UP_STEP,
        OP_PLACE,
        OP_NEXT,
        OP_FULL,
        OP_NOT_FOUND,
        OP_EMIT,
        OP_RESP
    } t_op;

    typedef struct packed {
        t_op     op;
        t_rd_sel rd_sel;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  present;
        logic  full;
        logic  del_tail;
        logic  root_due;
        logic  pop_tail;
        logic  down_moves;
        logic  up_moves;
        logic  moved;
        logic  emit_last;
        logic  out_free;
    } t_dp_sts;

    typedef struct packed {
        logic [HANDLE_W-1:0]  handle;
        logic [TIME_BITS-1:0] expiry;
    } t_entry;

endpackage

// ===== src/mhtq_dp.sv =====
// ----------------------------------------------------------------------------
// mhtq_dp
// Heap memory, handle-to-slot table, expired-handle buffer and result register.
// ----------------------------------------------------------------------------
module mhtq_dp import mhtq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [KIND_W-1:0]     i_in_kind,
    input  logic [HANDLE_W-1:0]   i_in_handle,
    input  logic [TIMEOUT_W-1:0]  i_in_timeout,
    input  logic [TIME_BITS-1:0]  i_in_now,
    input  logic                  i_out_ready,
    output t_dp_sts               o_sts,
    output logic                  o_out_valid,
    output t_status               o_out_status,
    output logic                  o_out_exp_valid,
    output logic [HANDLE_W-1:0]   o_out_exp_handle,
    output logic                  o_out_next_valid,
    output logic [WAIT_W-1:0]     o_out_next_wait,
    output logic                  o_out_last
);

    t_entry heap_mem [HEAP_DEPTH];
    logic [IDX_W-1:0] hs_mem [HANDLE_COUNT];
    logic [HANDLE_W-1:0] exp_mem [HEAP_DEPTH];

    t_kind                r_kind;
    logic [HANDLE_W-1:0]  r_h;
    logic [TIME_BITS-1:0] r_exp;
    logic [TIME_BITS-1:0] r_now;
    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_idx;
    t_entry               r_cur;
    logic                 r_moved;
    logic [CNT_W-1:0]     r_n;
    logic [IDX_W-1:0]     r_emit;
    t_status              r_status;
    logic                 r_next_valid;
    logic [WAIT_W-1:0]    r_next_wait;
    logic [HANDLE_COUNT-1:0] r_present;
    t_entry               r_ha;
    t_entry               r_hb;
    logic [IDX_W-1:0]     r_hs;
    logic [HANDLE_W-1:0]  r_buf;

    logic [TIME_BITS:0]   sum;
    logic [CNT_W-1:0]     cnt_m1;
    logic [CNT_W:0]       l_pos;
    logic [CNT_W:0]       r_pos;
    logic                 l_ok;
    logic                 r_ok;
    logic [IDX_W-1:0]     parent;
    logic [IDX_W-1:0]     rd_a;
    logic [IDX_W-1:0]     rd_b;
    logic [IDX_W-1:0]     best_idx;
    t_entry               best_ent;
    logic                 take;
    logic                 heap_we;
    logic [IDX_W-1:0]     heap_wa;
    t_entry               heap_wd;
    logic                 hs_we;
    logic [HANDLE_W-1:0]  hs_wa;
    logic                 buf_we;
    logic [TIME_BITS-1:0] diff;
    logic [WAIT_W-1:0]    wait_val;
    logic                 load_out;

    assign sum    = (TIME_BITS+1)'(i_in_now) + (TIME_BITS+1)'(i_in_timeout);
    assign cnt_m1 = r_count - CNT_W'(1);
    assign l_pos  = {1'b0, r_idx, 1'b1};
    assign r_pos  = {1'b0, r_idx, 1'b0} + (CNT_W+1)'(2);
    assign l_ok   = l_pos < {1'b0, r_count};
    assign r_ok   = r_pos < {1'b0, r_count};
    assign parent = (r_idx - IDX_W'(1)) >> 1;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_CHILD: begin
                rd_a = l_pos[IDX_W-1:0];
                rd_b = r_pos[IDX_W-1:0];
            end
            RD_PARENT: begin
                rd_a = parent;
                rd_b = parent;
            end
            default: begin
                rd_a = '0;
                rd_b = cnt_m1[IDX_W-1:0];
            end
        endcase
    end

    // Smaller child wins only when strictly smaller, left before right.
    always_comb begin
        best_idx = r_idx;
        best_ent = r_cur;
        take     = 1'b0;
        if (l_ok && (r_ha.expiry < r_cur.expiry)) begin
            best_idx = l_pos[IDX_W-1:0];
            best_ent = r_ha;
            take     = 1'b1;
        end
        if (r_ok && (r_hb.expiry < best_ent.expiry)) begin
            best_idx = r_pos[IDX_W-1:0];
            best_ent = r_hb;
            take     = 1'b1;
        end
    end

    always_comb begin
        heap_we = 1'b0;
        heap_wa = r_idx;
        heap_wd = r_cur;
        hs_we   = 1'b0;
        hs_wa   = r_cur.handle;
        case (i_cmd.op)
            OP_DOWN_STEP: begin
                heap_we = 1'b1;
                heap_wd = best_ent;
                hs_we   = 1'b1;
                hs_wa   = best_ent.handle;
            end
            OP_UP_STEP: begin
                heap_we = 1'b1;
                heap_wd = r_ha;
                hs_we   = 1'b1;
                hs_wa   = r_ha.handle;
            end
            OP_PLACE: begin
                heap_we = 1'b1;
                hs_we   = 1'b1;
            end
            default: begin
                heap_we = 1'b0;
            end
        endcase
    end

    assign buf_we   = (i_cmd.op == OP_POP_START) || (i_cmd.op == OP_POP_TAIL);
    assign diff     = r_ha.expiry - r_now;
    assign wait_val = (r_ha.expiry <= r_now) ? '0 :
                      (|diff[TIME_BITS-1:WAIT_W]) ? {WAIT_W{1'b1}} : diff[WAIT_W-1:0];
    assign load_out = (i_cmd.op == OP_EMIT) || (i_cmd.op == OP_RESP);

    always_ff @(posedge i_clk) begin
        if (heap_we) begin
            heap_mem[heap_wa] <= heap_wd;
        end
        r_ha <= heap_mem[rd_a];
        r_hb <= heap_mem[rd_b];
    end

    always_ff @(posedge i_clk) begin
        if (hs_we) begin
            hs_mem[hs_wa] <= heap_wa;
        end
        r_hs <= hs_mem[r_h];
    end

    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            exp_mem[r_n[IDX_W-1:0]] <= r_ha.handle;
        end
        r_buf <= exp_mem[r_emit];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_present   <= '0;
            o_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_ADD_START: begin
                    r_count        <= r_count + CNT_W'(1);
                    r_present[r_h] <= 1'b1;
                end
                OP_DEL_START, OP_DEL_TAIL: begin
                    r_count        <= cnt_m1;
                    r_present[r_h] <= 1'b0;
                end
                OP_POP_START, OP_POP_TAIL: begin
                    r_count                 <= cnt_m1;
                    r_present[r_ha.handle]  <= 1'b0;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
            if (load_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and result payload.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_kind   <= t_kind'(i_in_kind);
                r_h      <= i_in_handle;
                r_now    <= i_in_now;
                r_exp    <= sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
                r_n      <= '0;
                r_emit   <= '0;
                r_status <= ST_DONE;
            end
            OP_REARM_START: begin
                r_idx   <= r_hs;
                r_cur   <= '{handle: r_h, expiry: r_exp};
                r_moved <= 1'b0;
            end
            OP_ADD_START: begin
                r_idx   <= r_count[IDX_W-1:0];
                r_cur   <= '{handle: r_h, expiry: r_exp};
                r_moved <= 1'b0;
            end
            OP_DEL_START: begin
                r_idx   <= r_hs;
                r_cur   <= r_hb;
                r_moved <= 1'b0;
            end
            OP_POP_START: begin
                r_idx   <= '0;
                r_cur   <= r_hb;
                r_moved <= 1'b0;
                r_n     <= r_n + CNT_W'(1);
            end
            OP_POP_TAIL: begin
                r_n <= r_n + CNT_W'(1);
            end
            OP_DOWN_STEP: begin
                r_idx   <= best_idx;
                r_moved <= 1'b1;
            end
            OP_UP_STEP: begin
                r_idx <= parent;
            end
            OP_NEXT: begin
                r_next_valid <= (r_count != '0);
                r_next_wait  <= (r_count != '0) ? wait_val : '0;
            end
            OP_FULL: begin
                r_status <= ST_FULL;
            end
            OP_NOT_FOUND: begin
                r_status <= ST_NOT_FOUND;
            end
            OP_EMIT: begin
                r_emit           <= r_emit + IDX_W'(1);
                o_out_status     <= ST_DONE;
                o_out_exp_valid  <= (r_n != '0);
                o_out_exp_handle <= (r_n != '0) ? r_buf : '0;
                o_out_next_valid <= r_next_valid;
                o_out_next_wait  <= r_next_wait;
                o_out_last       <= o_sts.emit_last;
            end
            OP_RESP: begin
                o_out_status     <= r_status;
                o_out_exp_valid  <= 1'b0;
                o_out_exp_handle <= '0;
                o_out_next_valid <= 1'b0;
                o_out_next_wait  <= '0;
                o_out_last       <= 1'b1;
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    always_comb begin
        o_sts.kind       = r_kind;
        o_sts.present    = r_present[r_h];
        o_sts.full       = (r_count == CNT_W'(HEAP_DEPTH));
        o_sts.del_tail   = (r_hs == cnt_m1[IDX_W-1:0]);
        o_sts.root_due   = (r_count != '0) && (r_ha.expiry <= r_now);
        o_sts.pop_tail   = (r_count == CNT_W'(1));
        o_sts.down_moves = take;
        o_sts.up_moves   = (r_idx != '0) && (r_ha.expiry > r_cur.expiry);
        o_sts.moved      = r_moved;
        o_sts.emit_last  = (r_n == '0) || ({1'b0, r_emit} == (r_n - CNT_W'(1)));
        o_sts.out_free   = !o_out_valid || i_out_ready;
    end

endmodule

// ===== src/mhtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mhtq_ctrl
// Sequencer for lookups, sifts, tick pops and result delivery.
// ----------------------------------------------------------------------------
module mhtq_ctrl import mhtq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_START,
        S_DOWN_RD,
        S_DOWN_CMP,
        S_UP_RD,
        S_UP_CMP,
        S_TICK_RD,
        S_TICK_CHK,
        S_EMIT_RD,
        S_EMIT_WR,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state after_place;

    assign o_in_ready  = (r_state == S_IDLE);
    assign after_place = (i_sts.kind == KIND_TICK) ? S_TICK_RD : S_RESP;

    always_comb begin
        n_state      = r_state;
        o_cmd.op     = OP_NOP;
        o_cmd.rd_sel = RD_ENDS;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = (i_sts.kind == KIND_TICK) ? S_TICK_CHK : S_START;
            end
            S_START: begin
                n_state = S_RESP;
                if (i_sts.kind == KIND_ADD) begin
                    if (i_sts.present) begin
                        o_cmd.op = OP_REARM_START;
                        n_state  = S_DOWN_RD;
                    end else if (i_sts.full) begin
                        o_cmd.op = OP_FULL;
                    end else begin
                        o_cmd.op = OP_ADD_START;
                        n_state  = S_UP_RD;
                    end
                end else if (!i_sts.present) begin
                    o_cmd.op = OP_NOT_FOUND;
                end else if (i_sts.kind == KIND_ADJUST) begin
                    o_cmd.op = OP_REARM_START;
                    n_state  = S_DOWN_RD;
                end else if (i_sts.del_tail) begin
                    o_cmd.op = OP_DEL_TAIL;
                end else begin
                    o_cmd.op = OP_DEL_START;
                    n_state  = S_DOWN_RD;
                end
            end
            S_DOWN_RD: begin
                o_cmd.rd_sel = RD_CHILD;
                n_state      = S_DOWN_CMP;
            end
            S_DOWN_CMP: begin
                o_cmd.rd_sel = RD_CHILD;
                if (i_sts.down_moves) begin
                    o_cmd.op = OP_DOWN_STEP;
                    n_state  = S_DOWN_RD;
                end else if (i_sts.moved) begin
                    o_cmd.op = OP_PLACE;
                    n_state  = after_place;
                end else begin
                    n_state = S_UP_RD;
                end
            end
            S_UP_RD: begin
                o_cmd.rd_sel = RD_PARENT;
                n_state      = S_UP_CMP;
            end
            S_UP_CMP: begin
                o_cmd.rd_sel = RD_PARENT;
                if (i_sts.up_moves) begin
                    o_cmd.op = OP_UP_STEP;
                    n_state  = S_UP_RD;
                end else begin
                    o_cmd.op = OP_PLACE;
                    n_state  = after_place;
                end
            end
            S_TICK_RD: begin
                n_state = S_TICK_CHK;
            end
            S_TICK_CHK: begin
                if (i_sts.root_due && i_sts.pop_tail) begin
                    o_cmd.op = OP_POP_TAIL;
                    n_state  = S_TICK_RD;
                end else if (i_sts.root_due) begin
                    o_cmd.op = OP_POP_START;
                    n_state  = S_DOWN_RD;
                end else begin
                    o_cmd.op = OP_NEXT;
                    n_state  = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = i_sts.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_RESP;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/min_heap_timer_queue_top.sv =====
// ----------------------------------------------------------------------------
// min_heap_timer_queue_top
// Timer queue on a binary min-heap of expiry times with a handle-to-slot table.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Beat contents
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | tuser: kind; tdata: handle, timeout_ms, now_ms
//  m_axis   | out       | tuser: status; tdata: expired_valid, expired_handle,
//           |           | next_valid, next_wait_ms; tlast: last result of item
//
//  Add, adjust and delete leave the heap alone on errors and when the tail
//  entry is deleted; otherwise the entry is sifted, and each heap level it
//  travels costs one registered read of the heap memory and one compare and
//  write. A tick first checks the root; each expired timer is then popped
//  into the expired-handle buffer and the refilled root sifted down, and
//  once the root is not due the wait is computed and the result beats are
//  sent, one per buffered handle or a single one if none expired. The
//  synchronous reset clears the entry count and the presence bits; no memory
//  sweep is needed. One item is in work at a time; a stalled output beat
//  waits in the output register, and the next input beat is taken once the
//  last result of the item sits there.
//
module min_heap_timer_queue_top import mhtq_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [7:0] handle, [38:8] timeout_ms, [70:39] now_ms, [71] zero fill.
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] kind.
    input  logic [KIND_W-1:0]      s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] expired_valid, [8:1] expired_handle, [9] next_valid,
    // [40:10] next_wait_ms, [47:41] zero fill.
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    // [1:0] status.
    output logic [STATUS_W-1:0]    m_axis_tuser,
    output logic                   m_axis_tlast
);

    t_cmd                 cmd;
    t_dp_sts              sts;
    t_status              out_status;
    logic                 out_exp_valid;
    logic [HANDLE_W-1:0]  out_exp_handle;
    logic                 out_next_valid;
    logic [WAIT_W-1:0]    out_next_wait;

    // The controller sequences the datapath; all heap and table storage lives
    // in the datapath.
    mhtq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    mhtq_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_in_kind        (s_axis_tuser),
        .i_in_handle      (s_axis_tdata[7:0]),
        .i_in_timeout     (s_axis_tdata[38:8]),
        .i_in_now         (s_axis_tdata[70:39]),
        .i_out_ready      (m_axis_tready),
        .o_sts            (sts),
        .o_out_valid      (m_axis_tvalid),
        .o_out_status     (out_status),
        .o_out_exp_valid  (out_exp_valid),
        .o_out_exp_handle (out_exp_handle),
        .o_out_next_valid (out_next_valid),
        .o_out_next_wait  (out_next_wait),
        .o_out_last       (m_axis_tlast)
    );

    // Pack the result fields, lowest field in the lowest bits.
    assign m_axis_tdata = {7'd0, out_next_wait, out_next_valid, out_exp_handle,
                           out_exp_valid};
    assign m_axis_tuser = out_status;

`ifndef SYNTH
    // Once a beat is taken, the block is busy with it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again right after an accepted beat");

    // Error outcomes are always the single, final result of their item.
    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_DONE)) |-> m_axis_tlast)
        else $error("error result not marked last");

    // An expired handle is only reported by a successful tick.
    a_expired_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tuser == ST_DONE))
        else $error("expired handle reported with an error status");

    // A heap pop is only issued while the heap holds a due entry.
    a_pop_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cmd.op == OP_POP_START) || (cmd.op == OP_POP_TAIL)) |-> sts.root_due)
        else $error("pop issued without a due root");
`endif

endmodule
